### rtl/oase_pkg.sv
package oase_pkg;

  localparam int OpW     = 4;
  localparam int PosW    = 8;
  localparam int ValW    = 32;
  localparam int ResW    = 40;
  localparam int StatW   = 3;
  localparam int CntOutW = 9;

  typedef enum logic [OpW-1:0] {
    OP_APPEND  = 4'd0,
    OP_INSERT  = 4'd1,
    OP_DELETE  = 4'd2,
    OP_GET     = 4'd3,
    OP_SET     = 4'd4,
    OP_SEARCH  = 4'd5,
    OP_MAX     = 4'd6,
    OP_MIN     = 4'd7,
    OP_SUM     = 4'd8,
    OP_REVERSE = 4'd9
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    STEP_NONE           = 4'd0,
    STEP_WR_AT_CNT      = 4'd1,
    STEP_WR_AT_POS      = 4'd2,
    STEP_SHIFT_UP_START = 4'd3,
    STEP_SHIFT_UP       = 4'd4,
    STEP_READ_POS       = 4'd5,
    STEP_DEL_FIRST      = 4'd6,
    STEP_SHIFT_DN       = 4'd7,
    STEP_SCAN_START     = 4'd8,
    STEP_SCAN           = 4'd9,
    STEP_RV_START       = 4'd10,
    STEP_RV_RJ          = 4'd11,
    STEP_RV_WI          = 4'd12,
    STEP_RV_WJ          = 4'd13
  } step_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_e;

  typedef enum logic [2:0] {
    RES_KEEP    = 3'd0,
    RES_ZERO    = 3'd1,
    RES_OPERAND = 3'd2,
    RES_RDATA   = 3'd3,
    RES_MATCH   = 3'd4,
    RES_BEST    = 3'd5,
    RES_SUM     = 3'd6
  } res_e;

  typedef struct packed {
    logic    load_in;
    step_e   step;
    cnt_e    cnt;
    res_e    res;
    status_e status;
    logic    pick_max;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic few;
    logic up_more;
    logic del_more;
    logic dn_more;
    logic scan_last;
    logic match;
    logic rv_more;
    logic out_free;
  } flags_t;

endpackage

### rtl/oase_ram.sv
module oase_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/oase_dp.sv
module oase_dp
  import oase_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output flags_t                     flags_o,
  input  logic [PosW-1:0]            in_position_i,
  input  logic signed [ValW-1:0]     in_operand_value_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [StatW-1:0]           out_status_o,
  output logic signed [ResW-1:0]     out_result_value_o,
  output logic [PosW-1:0]            out_found_position_o,
  output logic [CntOutW-1:0]         out_entry_count_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int XW    = ((CNT_W > PosW) ? CNT_W : PosW) + 1;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] ptr2_q, ptr2_d;
  logic [CNT_W-1:0] at_q, at_next;
  logic             out_valid_q;

  logic [PosW-1:0]  pos_q;
  logic [ValW-1:0]  val_q;
  logic [ValW-1:0]  tmp_q;
  logic [ValW-1:0]  best_q, best_next;
  logic [ResW-1:0]  acc_q, acc_next;
  status_e          res_status_q;
  logic [ResW-1:0]  res_val_q;
  logic [PosW-1:0]  res_pos_q;
  logic [StatW-1:0] out_status_q;
  logic [ResW-1:0]  out_val_q;
  logic [PosW-1:0]  out_pos_q;
  logic [CntOutW-1:0] out_cnt_q;

  logic [XW-1:0] cnt_x, pos_x, ptr_x, ptr2_x, at_x;
  logic [XW-1:0] cnt_m1, ptr_m1, ptr_m2, ptr_p1, ptr_p2, pos_p1, ptr2_m1;

  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [ValW-1:0] wr_data, rd_data;
  logic            first, better;

  assign cnt_x  = {{(XW-CNT_W){1'b0}}, count_q};
  assign pos_x  = {{(XW-PosW){1'b0}}, pos_q};
  assign ptr_x  = {{(XW-CNT_W){1'b0}}, ptr_q};
  assign ptr2_x = {{(XW-CNT_W){1'b0}}, ptr2_q};
  assign at_x   = {{(XW-CNT_W){1'b0}}, at_next};

  assign cnt_m1  = cnt_x - XW'(1);
  assign ptr_m1  = ptr_x - XW'(1);
  assign ptr_m2  = ptr_x - XW'(2);
  assign ptr_p1  = ptr_x + XW'(1);
  assign ptr_p2  = ptr_x + XW'(2);
  assign pos_p1  = pos_x + XW'(1);
  assign ptr2_m1 = ptr2_x - XW'(1);

  always_comb begin
    flags_o.full       = (cnt_x == XW'(DEPTH));
    flags_o.empty      = (cnt_x == '0);
    flags_o.pos_gt_cnt = (pos_x > cnt_x);
    flags_o.pos_ge_cnt = (pos_x >= cnt_x);
    flags_o.few        = (cnt_x < XW'(2));
    flags_o.up_more    = (ptr_x > pos_p1);
    flags_o.del_more   = (pos_p1 < cnt_x);
    flags_o.dn_more    = (ptr_p2 < cnt_x);
    flags_o.scan_last  = (ptr_p1 == cnt_x);
    flags_o.match      = (rd_data == val_q);
    flags_o.rv_more    = (ptr_p2 < ptr2_x);
    flags_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_x[AW-1:0];
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = ptr_x[AW-1:0];
    case (cmd_i.step)
      STEP_WR_AT_CNT: begin
        wr_en   = 1'b1;
        wr_addr = cnt_x[AW-1:0];
        wr_data = val_q;
      end
      STEP_WR_AT_POS: begin
        wr_en   = 1'b1;
        wr_addr = pos_x[AW-1:0];
        wr_data = val_q;
      end
      STEP_SHIFT_UP_START: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[AW-1:0];
      end
      STEP_SHIFT_UP: begin
        wr_en   = 1'b1;
        rd_en   = flags_o.up_more;
        rd_addr = ptr_m2[AW-1:0];
      end
      STEP_READ_POS: begin
        rd_en   = 1'b1;
        rd_addr = pos_x[AW-1:0];
      end
      STEP_DEL_FIRST: begin
        rd_en   = flags_o.del_more;
        rd_addr = pos_p1[AW-1:0];
      end
      STEP_SHIFT_DN: begin
        wr_en   = 1'b1;
        rd_en   = flags_o.dn_more;
        rd_addr = ptr_p2[AW-1:0];
      end
      STEP_SCAN_START, STEP_RV_START: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      STEP_SCAN: begin
        rd_en   = !flags_o.scan_last;
        rd_addr = ptr_p1[AW-1:0];
      end
      STEP_RV_RJ: begin
        rd_en   = 1'b1;
        rd_addr = ptr2_x[AW-1:0];
      end
      STEP_RV_WI: begin
        wr_en   = 1'b1;
      end
      STEP_RV_WJ: begin
        wr_en   = 1'b1;
        wr_addr = ptr2_x[AW-1:0];
        wr_data = tmp_q;
        rd_en   = flags_o.rv_more;
        rd_addr = ptr_p1[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  oase_ram #(
    .WIDTH(ValW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign first     = (ptr_x == '0);
  assign better    = cmd_i.pick_max ? ($signed(rd_data) > $signed(best_q))
                                    : ($signed(rd_data) < $signed(best_q));
  assign best_next = (first || better) ? rd_data : best_q;
  assign at_next   = (first || better) ? ptr_q : at_q;
  assign acc_next  = (first ? '0 : acc_q) + {{(ResW-ValW){rd_data[ValW-1]}}, rd_data};

  always_comb begin
    ptr_d  = ptr_q;
    ptr2_d = ptr2_q;
    case (cmd_i.step)
      STEP_SHIFT_UP_START: ptr_d = count_q;
      STEP_SHIFT_UP:       ptr_d = ptr_m1[CNT_W-1:0];
      STEP_DEL_FIRST:      ptr_d = pos_x[CNT_W-1:0];
      STEP_SHIFT_DN:       ptr_d = ptr_p1[CNT_W-1:0];
      STEP_SCAN_START:     ptr_d = '0;
      STEP_SCAN:           ptr_d = ptr_p1[CNT_W-1:0];
      STEP_RV_START: begin
        ptr_d  = '0;
        ptr2_d = cnt_m1[CNT_W-1:0];
      end
      STEP_RV_WJ: begin
        ptr_d  = ptr_p1[CNT_W-1:0];
        ptr2_d = ptr2_m1[CNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cmd_i.cnt)
      CNT_INC: count_d = count_q + CNT_W'(1);
      CNT_DEC: count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      ptr2_q      <= '0;
      at_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      ptr2_q  <= ptr2_d;
      if (cmd_i.step == STEP_SCAN) begin
        at_q <= at_next;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pos_q <= in_position_i;
      val_q <= in_operand_value_i;
    end
    if (cmd_i.step == STEP_RV_RJ) begin
      tmp_q <= rd_data;
    end
    if (cmd_i.step == STEP_SCAN) begin
      best_q <= best_next;
      acc_q  <= acc_next;
    end
    if (cmd_i.res != RES_KEEP) begin
      res_status_q <= cmd_i.status;
    end
    case (cmd_i.res)
      RES_ZERO: begin
        res_val_q <= '0;
        res_pos_q <= '0;
      end
      RES_OPERAND: begin
        res_val_q <= {{(ResW-ValW){val_q[ValW-1]}}, val_q};
        res_pos_q <= '0;
      end
      RES_RDATA: begin
        res_val_q <= {{(ResW-ValW){rd_data[ValW-1]}}, rd_data};
        res_pos_q <= '0;
      end
      RES_MATCH: begin
        res_val_q <= {{(ResW-ValW){val_q[ValW-1]}}, val_q};
        res_pos_q <= ptr_x[PosW-1:0];
      end
      RES_BEST: begin
        res_val_q <= {{(ResW-ValW){best_next[ValW-1]}}, best_next};
        res_pos_q <= at_x[PosW-1:0];
      end
      RES_SUM: begin
        res_val_q <= acc_next;
        res_pos_q <= '0;
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_val_q    <= res_val_q;
      out_pos_q    <= res_pos_q;
      out_cnt_q    <= cnt_x[CntOutW-1:0];
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_status_o         = out_status_q;
  assign out_result_value_o   = out_val_q;
  assign out_found_position_o = out_pos_q;
  assign out_entry_count_o    = out_cnt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= XW'(DEPTH))
    else $error("entry count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write at the same entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1))
             || (count_q + CNT_W'(1) == $past(count_q)))
    else $error("entry count moved by more than one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result load lost");

endmodule

### rtl/oase_ctrl.sv
module oase_ctrl
  import oase_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [OpW-1:0] in_op_i,
  input  flags_t         flags_i,
  output cmd_t           cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_SHIFT_UP  = 4'd2;
  localparam logic [3:0] S_INS_LAST  = 4'd3;
  localparam logic [3:0] S_DEL_FIRST = 4'd4;
  localparam logic [3:0] S_SHIFT_DN  = 4'd5;
  localparam logic [3:0] S_GET       = 4'd6;
  localparam logic [3:0] S_SCAN      = 4'd7;
  localparam logic [3:0] S_RV_RJ     = 4'd8;
  localparam logic [3:0] S_RV_WI     = 4'd9;
  localparam logic [3:0] S_RV_WJ     = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  logic [3:0] state_q, state_d;
  op_e        op_q, op_d;
  cmd_t       cmd;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    cmd.load_in  = 1'b0;
    cmd.step     = STEP_NONE;
    cmd.cnt      = CNT_HOLD;
    cmd.res      = RES_KEEP;
    cmd.status   = ST_OK;
    cmd.pick_max = (op_q == OP_MAX);
    cmd.out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          op_d        = op_e'(in_op_i);
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (op_q)
          OP_APPEND: begin
            if (flags_i.full) begin
              cmd.res    = RES_ZERO;
              cmd.status = ST_FULL;
            end else begin
              cmd.step = STEP_WR_AT_CNT;
              cmd.cnt  = CNT_INC;
              cmd.res  = RES_OPERAND;
            end
          end
          OP_INSERT: begin
            if (flags_i.pos_gt_cnt) begin
              cmd.res    = RES_ZERO;
              cmd.status = ST_BAD_INDEX;
            end else if (flags_i.full) begin
              cmd.res    = RES_ZERO;
              cmd.status = ST_FULL;
            end else if (flags_i.pos_ge_cnt) begin
              cmd.step = STEP_WR_AT_POS;
              cmd.cnt  = CNT_INC;
              cmd.res  = RES_OPERAND;
            end else begin
              cmd.step = STEP_SHIFT_UP_START;
              state_d  = S_SHIFT_UP;
            end
          end
          OP_DELETE, OP_GET, OP_SET: begin
            if (flags_i.empty) begin
              cmd.res    = RES_ZERO;
              cmd.status = ST_EMPTY;
            end else if (flags_i.pos_ge_cnt) begin
              cmd.res    = RES_ZERO;
              cmd.status = ST_BAD_INDEX;
            end else if (op_q == OP_SET) begin
              cmd.step = STEP_WR_AT_POS;
              cmd.res  = RES_OPERAND;
            end else begin
              cmd.step = STEP_READ_POS;
              state_d  = (op_q == OP_DELETE) ? S_DEL_FIRST : S_GET;
            end
          end
          OP_SEARCH, OP_MAX, OP_MIN: begin
            if (flags_i.empty) begin
              cmd.res    = RES_ZERO;
              cmd.status = ST_EMPTY;
            end else begin
              cmd.step = STEP_SCAN_START;
              state_d  = S_SCAN;
            end
          end
          OP_SUM: begin
            if (flags_i.empty) begin
              cmd.res = RES_ZERO;
            end else begin
              cmd.step = STEP_SCAN_START;
              state_d  = S_SCAN;
            end
          end
          OP_REVERSE: begin
            if (flags_i.few) begin
              cmd.res = RES_ZERO;
            end else begin
              cmd.step = STEP_RV_START;
              state_d  = S_RV_RJ;
            end
          end
          default: begin
            cmd.res = RES_ZERO;
          end
        endcase
      end
      S_SHIFT_UP: begin
        cmd.step = STEP_SHIFT_UP;
        if (!flags_i.up_more) begin
          state_d = S_INS_LAST;
        end
      end
      S_INS_LAST: begin
        cmd.step = STEP_WR_AT_POS;
        cmd.cnt  = CNT_INC;
        cmd.res  = RES_OPERAND;
        state_d  = S_DONE;
      end
      S_DEL_FIRST: begin
        cmd.step = STEP_DEL_FIRST;
        cmd.res  = RES_RDATA;
        if (flags_i.del_more) begin
          state_d = S_SHIFT_DN;
        end else begin
          cmd.cnt = CNT_DEC;
          state_d = S_DONE;
        end
      end
      S_SHIFT_DN: begin
        cmd.step = STEP_SHIFT_DN;
        if (!flags_i.dn_more) begin
          cmd.cnt = CNT_DEC;
          state_d = S_DONE;
        end
      end
      S_GET: begin
        cmd.res = RES_RDATA;
        state_d = S_DONE;
      end
      S_SCAN: begin
        cmd.step = STEP_SCAN;
        case (op_q)
          OP_SEARCH: begin
            if (flags_i.match) begin
              cmd.res = RES_MATCH;
              state_d = S_DONE;
            end else if (flags_i.scan_last) begin
              cmd.res    = RES_ZERO;
              cmd.status = ST_NOT_FOUND;
              state_d    = S_DONE;
            end
          end
          OP_MAX, OP_MIN: begin
            if (flags_i.scan_last) begin
              cmd.res = RES_BEST;
              state_d = S_DONE;
            end
          end
          default: begin
            if (flags_i.scan_last) begin
              cmd.res = RES_SUM;
              state_d = S_DONE;
            end
          end
        endcase
      end
      S_RV_RJ: begin
        cmd.step = STEP_RV_RJ;
        state_d  = S_RV_WI;
      end
      S_RV_WI: begin
        cmd.step = STEP_RV_WI;
        state_d  = S_RV_WJ;
      end
      S_RV_WJ: begin
        cmd.step = STEP_RV_WJ;
        if (flags_i.rv_more) begin
          state_d = S_RV_RJ;
        end else begin
          cmd.res = RES_ZERO;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (flags_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_APPEND;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item taken while one is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !flags_i.out_free) |=> (state_q == S_DONE))
    else $error("result dropped while output is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cmd_o.step == STEP_NONE && cmd_o.cnt == CNT_HOLD))
    else $error("entry store touched while idle");

endmodule

### rtl/ordered_array_store_engine_unit.sv
// Packed list of up to DEPTH signed 32-bit entries with a count, one operation per item
// (append, insert, delete, get, set, search, max, min, sum, reverse), one result per item.
// Items are taken one at a time; the entries sit in a single-port-read RAM. Insert,
// delete, search, max, min and sum move one entry per cycle; reverse swaps each pair by
// reading the far entry, then writing the near one and the far one. Insert shifts the
// entries from the end down to the position up by one, then writes the operand; delete
// returns the entry at the position and shifts the rest down; search stops at the first
// match; max, min and sum visit every entry. The next item is taken once the result is
// loaded into the output register, even if that result is still stalled. Sum wraps to
// 40 bits when DEPTH exceeds 256. No clearing pass after reset.
module ordered_array_store_engine_unit
  import oase_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [OpW-1:0]         in_op_i,
  input  logic [PosW-1:0]        in_position_i,
  input  logic signed [ValW-1:0] in_operand_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [StatW-1:0]       out_status_o,
  output logic signed [ResW-1:0] out_result_value_o,
  output logic [PosW-1:0]        out_found_position_o,
  output logic [CntOutW-1:0]     out_entry_count_o
);

  cmd_t   cmd;
  flags_t flags;

  oase_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_op_i   (in_op_i),
    .flags_i   (flags),
    .cmd_o     (cmd)
  );

  oase_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .flags_o             (flags),
    .in_position_i       (in_position_i),
    .in_operand_value_i  (in_operand_value_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .out_status_o        (out_status_o),
    .out_result_value_o  (out_result_value_o),
    .out_found_position_o(out_found_position_o),
    .out_entry_count_o   (out_entry_count_o)
  );

endmodule
